// ===== rtl/core/sc1dec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc1dec_pkg
// constants and the US key map for the scan code set 1 decoder
// ----------------------------------------------------------------------------
package sc1dec_pkg;

  localparam logic [7:0] PREFIX_EXT = 8'hE0;

  // key codes with bit 7 removed
  localparam logic [6:0] SC_LSHIFT = 7'h2A;
  localparam logic [6:0] SC_RSHIFT = 7'h36;
  localparam logic [6:0] SC_CTRL   = 7'h1D;
  localparam logic [6:0] SC_ALT    = 7'h38;
  localparam logic [6:0] SC_CAPS   = 7'h3A;
  localparam logic [6:0] SC_NUM    = 7'h45;
  localparam logic [6:0] SC_SCROLL = 7'h46;

  localparam logic [7:0] ASC_BS  = 8'h08;
  localparam logic [7:0] ASC_TAB = 8'h09;
  localparam logic [7:0] ASC_LF  = 8'h0A;
  localparam logic [7:0] ASC_GRV = 8'h60;

  // lower / upper US map, zero where the key gives no character
  function automatic logic [6:0] sc1dec_char(input logic [6:0] key, input logic upper);
    logic [7:0] c;
    c = 8'h00;
    case (key)
      7'h02: c = upper ? "!" : "1";
      7'h03: c = upper ? "@" : "2";
      7'h04: c = upper ? "#" : "3";
      7'h05: c = upper ? "$" : "4";
      7'h06: c = upper ? "%" : "5";
      7'h07: c = upper ? "^" : "6";
      7'h08: c = upper ? "&" : "7";
      7'h09: c = upper ? "*" : "8";
      7'h0A: c = upper ? "(" : "9";
      7'h0B: c = upper ? ")" : "0";
      7'h0C: c = upper ? "_" : "-";
      7'h0D: c = upper ? "+" : "=";
      7'h0E: c = ASC_BS;
      7'h0F: c = ASC_TAB;
      7'h10: c = upper ? "Q" : "q";
      7'h11: c = upper ? "W" : "w";
      7'h12: c = upper ? "E" : "e";
      7'h13: c = upper ? "R" : "r";
      7'h14: c = upper ? "T" : "t";
      7'h15: c = upper ? "Y" : "y";
      7'h16: c = upper ? "U" : "u";
      7'h17: c = upper ? "I" : "i";
      7'h18: c = upper ? "O" : "o";
      7'h19: c = upper ? "P" : "p";
      7'h1A: c = upper ? "{" : "[";
      7'h1B: c = upper ? "}" : "]";
      7'h1C: c = ASC_LF;
      7'h1E: c = upper ? "A" : "a";
      7'h1F: c = upper ? "S" : "s";
      7'h20: c = upper ? "D" : "d";
      7'h21: c = upper ? "F" : "f";
      7'h22: c = upper ? "G" : "g";
      7'h23: c = upper ? "H" : "h";
      7'h24: c = upper ? "J" : "j";
      7'h25: c = upper ? "K" : "k";
      7'h26: c = upper ? "L" : "l";
      7'h27: c = upper ? ":" : ";";
      7'h28: c = upper ? "\"" : "'";
      7'h29: c = upper ? "~" : ASC_GRV;
      7'h2B: c = upper ? "|" : "\\";
      7'h2C: c = upper ? "Z" : "z";
      7'h2D: c = upper ? "X" : "x";
      7'h2E: c = upper ? "C" : "c";
      7'h2F: c = upper ? "V" : "v";
      7'h30: c = upper ? "B" : "b";
      7'h31: c = upper ? "N" : "n";
      7'h32: c = upper ? "M" : "m";
      7'h33: c = upper ? "<" : ",";
      7'h34: c = upper ? ">" : ".";
      7'h35: c = upper ? "?" : "/";
      7'h37: c = "*";
      7'h39: c = " ";
      7'h47: c = "7";
      7'h48: c = "8";
      7'h49: c = "9";
      7'h4A: c = "-";
      7'h4B: c = "4";
      7'h4C: c = "5";
      7'h4D: c = "6";
      7'h4E: c = "+";
      7'h4F: c = "1";
      7'h50: c = "2";
      7'h51: c = "3";
      7'h52: c = "0";
      7'h53: c = ".";
      default: c = 8'h00;
    endcase
    return c[6:0];
  endfunction

endpackage

// ===== rtl/core/scancode_set1_to_ascii_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_set1_to_ascii_decoder
// scan code set 1 bytes to ascii with modifier and lock tracking
// ----------------------------------------------------------------------------
// usage:
//   in_valid / in_ready carry one received scan code byte per request.
//   out_valid / out_ready carry exactly one result request per input byte,
//   in order: the ascii code (zero when none), the led write strobe, the led
//   mask and the modifier and lock flags as they stand after that byte.
//   a byte accepted on in_valid / in_ready is registered in the input stage,
//   decoded combinationally from that register and loaded into the result
//   register when that register is free.
//   throughput: one byte per cycle while out_ready holds; the decode is one
//   table lookup and a few flag updates between the two registers.
//   the flags update when a byte moves from the input stage to the result
//   register, so bytes take effect strictly in arrival order.
//   reset (rst_n low, synchronous) clears all flags, the led mask and both
//   valid bits.
//   when the receiver stalls, the result register holds and the input stage
//   keeps one more byte; in_ready drops only when both are full.
// ----------------------------------------------------------------------------
module scancode_set1_to_ascii_decoder
  import sc1dec_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_scancode,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char_code,
  output logic       out_char_valid,
  output logic       out_led_write,
  output logic [2:0] out_led_mask,
  output logic       out_shift_held,
  output logic       out_ctrl_held,
  output logic       out_alt_held,
  output logic       out_caps_lock_on,
  output logic       out_num_lock_on,
  output logic       out_scroll_lock_on,
  output logic       out_key_released
);

  // input stage
  logic       in_vld_r;
  logic [7:0] in_code_r;

  // result register
  logic       out_vld_r;
  logic [6:0] char_r;
  logic       char_vld_r;
  logic       led_wr_r;
  logic       rel_r;

  // modifier and lock state; the led mask is {caps, num, scroll}, wired
  // straight from the lock flags
  logic shift_r, ctrl_r, alt_r, caps_r, num_r, scroll_r;
  logic shift_nxt, ctrl_nxt, alt_nxt, caps_nxt, num_nxt, scroll_nxt;

  logic [6:0] key;
  logic       is_prefix;
  logic [6:0] char_nxt;
  logic       led_wr_nxt;
  logic       rel_nxt;
  logic       load_out;

  // the result register takes a new request when it is empty or being drained
  assign load_out = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || load_out;

  assign key       = in_code_r[6:0];
  assign is_prefix = (in_code_r == PREFIX_EXT);

  // decode of the byte in the input stage
  always_comb begin
    shift_nxt  = shift_r;
    ctrl_nxt   = ctrl_r;
    alt_nxt    = alt_r;
    caps_nxt   = caps_r;
    num_nxt    = num_r;
    scroll_nxt = scroll_r;
    char_nxt   = 7'd0;
    led_wr_nxt = 1'b0;
    rel_nxt    = 1'b0;
    if (!is_prefix) begin
      if (in_code_r[7]) begin
        // release: only held modifiers react
        rel_nxt = 1'b1;
        case (key)
          SC_LSHIFT, SC_RSHIFT: shift_nxt = 1'b0;
          SC_CTRL:              ctrl_nxt  = 1'b0;
          SC_ALT:               alt_nxt   = 1'b0;
          default: ;
        endcase
      end else begin
        case (key)
          SC_LSHIFT, SC_RSHIFT: shift_nxt = 1'b1;
          SC_CTRL:              ctrl_nxt  = 1'b1;
          SC_ALT:               alt_nxt   = 1'b1;
          SC_CAPS: begin
            caps_nxt   = !caps_r;
            led_wr_nxt = 1'b1;
          end
          SC_NUM: begin
            num_nxt    = !num_r;
            led_wr_nxt = 1'b1;
          end
          SC_SCROLL: begin
            scroll_nxt = !scroll_r;
            led_wr_nxt = 1'b1;
          end
          // keys at or above the end of the map fall to zero in the lookup
          default: char_nxt = sc1dec_char(key, shift_r ^ caps_r);
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      shift_r   <= 1'b0;
      ctrl_r    <= 1'b0;
      alt_r     <= 1'b0;
      caps_r    <= 1'b0;
      num_r     <= 1'b0;
      scroll_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (load_out) begin
        out_vld_r <= 1'b1;
        shift_r   <= shift_nxt;
        ctrl_r    <= ctrl_nxt;
        alt_r     <= alt_nxt;
        caps_r    <= caps_nxt;
        num_r     <= num_nxt;
        scroll_r  <= scroll_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_code_r <= in_scancode;
    end
    if (load_out) begin
      char_r     <= char_nxt;
      char_vld_r <= (char_nxt != 7'd0);
      led_wr_r   <= led_wr_nxt;
      rel_r      <= rel_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_char_code      = char_r;
  assign out_char_valid     = char_vld_r;
  assign out_led_write      = led_wr_r;
  assign out_led_mask       = {caps_r, num_r, scroll_r};
  assign out_shift_held     = shift_r;
  assign out_ctrl_held      = ctrl_r;
  assign out_alt_held       = alt_r;
  assign out_caps_lock_on   = caps_r;
  assign out_num_lock_on    = num_r;
  assign out_scroll_lock_on = scroll_r;
  assign out_key_released   = rel_r;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the scan code set 1 to ascii decoder
// ----------------------------------------------------------------------------
// a short directed run covers table bounds, prefix, modifiers and lock keys.
// random typing bursts follow: modifiers held around key press/release pairs,
// prefixed ctrl/alt, lock toggles, dropped releases and raw noise bytes.
// every accepted byte runs through a local decoder model, and every result
// is compared field by field with the oldest predicted report.
// ----------------------------------------------------------------------------
module tb;
  import sc1dec_pkg::*;

  localparam int          CLK_HALF     = 6;
  localparam int          NUM_RANDOM   = 1750;
  localparam int          STALL_PCT    = 36;
  localparam int          WATCHDOG_MAX = 2000;
  localparam int          DRAIN_CYCLES = 12;
  localparam logic [7:0]  RELEASE_BIT  = 8'h80;
  localparam logic [6:0]  KEY_LIMIT    = 7'h59;
  localparam logic [7:0]  LAST_KEY     = 8'h58;
  localparam int          LED_SCROLL   = 0;
  localparam int          LED_NUM      = 1;
  localparam int          LED_CAPS     = 2;

  // stretch of cycles where neither side idles
  localparam int          QUIET_FROM   = 1200;
  localparam int          QUIET_TO     = 1900;

  typedef struct packed {
    logic [6:0] char_code;
    logic       char_valid;
    logic       led_write;
    logic [2:0] led_mask;
    logic       shift_held;
    logic       ctrl_held;
    logic       alt_held;
    logic       caps_on;
    logic       num_on;
    logic       scroll_on;
    logic       released;
  } key_report_t;

  // ascii per key code, unshifted and shifted, zero for keys with no character
  byte unsigned lower_chars [0:88] = '{
    0,   0,   "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", ASC_BS, ASC_TAB,
    "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", ASC_LF, 0, "a", "s",
    "d", "f", "g", "h", "j", "k", "l", ";", "'", ASC_GRV, 0, "\\", "z", "x", "c", "v",
    "b", "n", "m", ",", ".", "/", 0,   "*", 0,   " ", 0,   0,   0,   0,   0,   0,
    0,   0,   0,   0,   0,   0,   0,   "7", "8", "9", "-", "4", "5", "6", "+", "1",
    "2", "3", "0", ".", 0,   0,   0,   0,   0
  };

  byte unsigned upper_chars [0:88] = '{
    0,   0,   "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+", ASC_BS, ASC_TAB,
    "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", ASC_LF, 0, "A", "S",
    "D", "F", "G", "H", "J", "K", "L", ":", "\"", "~", 0,  "|", "Z", "X", "C", "V",
    "B", "N", "M", "<", ">", "?", 0,   "*", 0,   " ", 0,   0,   0,   0,   0,   0,
    0,   0,   0,   0,   0,   0,   0,   "7", "8", "9", "-", "4", "5", "6", "+", "1",
    "2", "3", "0", ".", 0,   0,   0,   0,   0
  };

  // dut ports; the inputs are known from time zero
  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [7:0] in_scancode = 8'h00;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [6:0] out_char_code;
  logic       out_char_valid;
  logic       out_led_write;
  logic [2:0] out_led_mask;
  logic       out_shift_held;
  logic       out_ctrl_held;
  logic       out_alt_held;
  logic       out_caps_lock_on;
  logic       out_num_lock_on;
  logic       out_scroll_lock_on;
  logic       out_key_released;

  // bytes waiting to be sent and reports waiting to come back
  logic [7:0]  scancode_fifo [$];
  key_report_t key_reports   [$];

  // keyboard state as the decoder should track it
  logic       shift_q, ctrl_q, alt_q;
  logic       caps_q, num_q, scroll_q;
  logic [2:0] leds_q;

  int unsigned bytes_offered  = 0;
  int unsigned bytes_accepted = 0;
  int unsigned cyc            = 0;
  int unsigned idle_cycles    = 0;
  int unsigned errors         = 0;

  scancode_set1_to_ascii_decoder dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_scancode        (in_scancode),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_char_code      (out_char_code),
    .out_char_valid     (out_char_valid),
    .out_led_write      (out_led_write),
    .out_led_mask       (out_led_mask),
    .out_shift_held     (out_shift_held),
    .out_ctrl_held      (out_ctrl_held),
    .out_alt_held       (out_alt_held),
    .out_caps_lock_on   (out_caps_lock_on),
    .out_num_lock_on    (out_num_lock_on),
    .out_scroll_lock_on (out_scroll_lock_on),
    .out_key_released   (out_key_released)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // random idling on either side, switched off inside the quiet stretch
  function automatic bit idle_now();
    if (cyc >= QUIET_FROM && cyc < QUIET_TO) begin
      return 1'b0;
    end
    return $urandom_range(99) < STALL_PCT;
  endfunction

  // advance the keyboard state by one byte and give the report it causes
  function automatic key_report_t decode_scancode(input logic [7:0] sc);
    key_report_t r;
    logic [6:0]  key;
    logic        upper;
    key = sc[6:0];
    r = '0;
    if (sc == PREFIX_EXT) begin
      // prefix is dropped, the next byte decodes as a plain key
    end else if (sc[7]) begin
      r.released = 1'b1;
      if (key == SC_LSHIFT || key == SC_RSHIFT) begin
        shift_q = 1'b0;
      end else if (key == SC_CTRL) begin
        ctrl_q = 1'b0;
      end else if (key == SC_ALT) begin
        alt_q = 1'b0;
      end
    end else if (key < KEY_LIMIT) begin
      if (key == SC_LSHIFT || key == SC_RSHIFT) begin
        shift_q = 1'b1;
      end else if (key == SC_CTRL) begin
        ctrl_q = 1'b1;
      end else if (key == SC_ALT) begin
        alt_q = 1'b1;
      end else if (key == SC_CAPS) begin
        caps_q             = ~caps_q;
        leds_q[LED_CAPS]   = ~leds_q[LED_CAPS];
        r.led_write        = 1'b1;
      end else if (key == SC_NUM) begin
        num_q              = ~num_q;
        leds_q[LED_NUM]    = ~leds_q[LED_NUM];
        r.led_write        = 1'b1;
      end else if (key == SC_SCROLL) begin
        scroll_q           = ~scroll_q;
        leds_q[LED_SCROLL] = ~leds_q[LED_SCROLL];
        r.led_write        = 1'b1;
      end else begin
        // shift and caps lock cancel each other
        upper = shift_q ^ caps_q;
        r.char_code = upper ? upper_chars[key][6:0] : lower_chars[key][6:0];
      end
    end
    r.char_valid = (r.char_code != 7'd0);
    r.led_mask   = leds_q;
    r.shift_held = shift_q;
    r.ctrl_held  = ctrl_q;
    r.alt_held   = alt_q;
    r.caps_on    = caps_q;
    r.num_on     = num_q;
    r.scroll_on  = scroll_q;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // input driver: changes only at the falling edge, holds a request until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (bytes_accepted == bytes_offered) begin
      if (scancode_fifo.size() > 0 && !idle_now()) begin
        in_scancode <= scancode_fifo.pop_front();
        in_valid    <= 1'b1;
        bytes_offered++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !idle_now();
    end
  end

  // monitor: predict on each accepted byte, check each accepted result
  always @(posedge clk) begin
    key_report_t got, want;
    bit          moved;
    moved = 1'b0;
    if (!rst_n) begin
      shift_q  = 1'b0;
      ctrl_q   = 1'b0;
      alt_q    = 1'b0;
      caps_q   = 1'b0;
      num_q    = 1'b0;
      scroll_q = 1'b0;
      leds_q   = 3'b000;
    end else begin
      cyc++;
      if (in_valid && in_ready) begin
        key_reports.push_back(decode_scancode(in_scancode));
        bytes_accepted++;
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        got = '{out_char_code, out_char_valid, out_led_write, out_led_mask,
                out_shift_held, out_ctrl_held, out_alt_held, out_caps_lock_on,
                out_num_lock_on, out_scroll_lock_on, out_key_released};
        if (key_reports.size() == 0) begin
          $error("result with no byte outstanding: %h", got);
          errors++;
        end else begin
          want = key_reports.pop_front();
          check_field("char_code",      want.char_code,  got.char_code);
          check_field("char_valid",     want.char_valid, got.char_valid);
          check_field("led_write",      want.led_write,  got.led_write);
          check_field("led_mask",       want.led_mask,   got.led_mask);
          check_field("shift_held",     want.shift_held, got.shift_held);
          check_field("ctrl_held",      want.ctrl_held,  got.ctrl_held);
          check_field("alt_held",       want.alt_held,   got.alt_held);
          check_field("caps_lock_on",   want.caps_on,    got.caps_on);
          check_field("num_lock_on",    want.num_on,     got.num_on);
          check_field("scroll_lock_on", want.scroll_on,  got.scroll_on);
          check_field("key_released",   want.released,   got.released);
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // watchdog on a stuck handshake
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("scancode_set1_to_ascii_decoder: mismatch");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    scancode_fifo.push_back(b);
  endtask

  // one typing burst: optional modifier held around a few keys
  task automatic queue_burst();
    int         modsel;
    int         nkeys;
    logic [7:0] modkey;
    logic [7:0] k;
    modsel = $urandom_range(3);
    case (modsel)
      1:       modkey = $urandom_range(1) ? {1'b0, SC_LSHIFT} : {1'b0, SC_RSHIFT};
      2:       modkey = {1'b0, SC_CTRL};
      3:       modkey = {1'b0, SC_ALT};
      default: modkey = 8'h00;
    endcase
    if (modsel != 0) begin
      // right ctrl and right alt come with the extended prefix
      if (modsel >= 2 && $urandom_range(2) == 0) begin
        push_byte(PREFIX_EXT);
      end
      push_byte(modkey);
    end
    nkeys = $urandom_range(1, 6);
    repeat (nkeys) begin
      if ($urandom_range(14) == 0) begin
        case ($urandom_range(2))
          0:       k = {1'b0, SC_CAPS};
          1:       k = {1'b0, SC_NUM};
          default: k = {1'b0, SC_SCROLL};
        endcase
      end else begin
        k = 8'($urandom_range(LAST_KEY));
      end
      if ($urandom_range(9) == 0) begin
        push_byte(PREFIX_EXT);
      end
      push_byte(k);
      // now and then the release gets lost
      if ($urandom_range(9) != 0) begin
        push_byte(k | RELEASE_BIT);
      end
    end
    if (modsel != 0 && $urandom_range(7) != 0) begin
      if (modsel == 1) begin
        // either shift release clears the shared flag
        modkey = $urandom_range(1) ? {1'b0, SC_LSHIFT} : {1'b0, SC_RSHIFT};
      end
      push_byte(modkey | RELEASE_BIT);
    end
  endtask

  // stimulus and end of run
  initial begin
    logic [7:0] directed [] = '{
      8'h00,                       // lowest byte, key with no character
      8'hFF,                       // highest byte, release of an unknown key
      8'h59,                       // first press above the key table
      8'h1E,                       // plain 'a'
      8'h2A, 8'h1E, 8'hB6,         // left shift, 'A', right shift release
      8'h36, 8'hAA,                // right shift, left shift release
      8'h3A, 8'h1E,                // caps on, 'A'
      8'h2A, 8'h1E, 8'hAA,         // shift with caps gives lower case
      8'h3A, 8'h45, 8'h46,         // caps off, num and scroll toggle
      8'hE0, 8'h1D, 8'hE0, 8'h9D,  // right ctrl press and release
      8'h38, 8'hB8,                // alt press and release
      8'h9E,                       // release of a character key
      8'h3B                        // function key without a character
    };
    int n_random;
    foreach (directed[i]) begin
      push_byte(directed[i]);
    end
    n_random = 0;
    while (n_random < NUM_RANDOM) begin
      if ($urandom_range(99) < 12) begin
        push_byte(8'($urandom_range(255)));
        n_random++;
      end else begin
        n_random -= scancode_fifo.size();
        queue_burst();
        n_random += scancode_fifo.size();
      end
    end

    // reset once, released on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (scancode_fifo.size() != 0 || bytes_accepted != bytes_offered ||
           key_reports.size() != 0) begin
      @(posedge clk);
    end
    // let any stray result show up
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("scancode_set1_to_ascii_decoder: match");
    end else begin
      $display("scancode_set1_to_ascii_decoder: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sc1dec_pkg.sv
rtl/core/scancode_set1_to_ascii_decoder.sv
verif/tb.sv
